### hw/rtl/complex_multiply_magnitude_phase_core_macros.svh
// Assertion macros shared by the complex multiply magnitude and phase core.
`ifndef COMPLEX_MULTIPLY_MAGNITUDE_PHASE_CORE_MACROS_SVH
`define COMPLEX_MULTIPLY_MAGNITUDE_PHASE_CORE_MACROS_SVH

// Checks that a consequent holds in the same cycle as its antecedent.
`define CMMP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a consequent holds after its antecedent, delayed by the count given as n.
`define CMMP_ASSERT_DLY(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

### hw/rtl/cmmp_pkg.sv
// Shared types and constants of the complex multiply magnitude and phase core.
`timescale 1ns / 1ps
package cmmp_pkg;

  localparam int XY_WIDTH    = 64;
  localparam int Z_WIDTH     = 35;
  localparam int MAG_WIDTH   = 32;
  localparam int PHASE_WIDTH = 16;
  localparam int GAIN_WIDTH  = 32;
  localparam int PHASE_LIMIT = 25736;

  localparam logic signed [Z_WIDTH-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic [GAIN_WIDTH-1:0]     GAIN_LIMIT  = 32'h9B74EDA8;
  localparam logic [63:0]               GAIN_TAIL   = 64'd1738754331;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
    32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [XY_WIDTH-1:0] x;
    logic signed [XY_WIDTH-1:0] y;
    logic signed [Z_WIDTH-1:0]  z;
    logic                       zero;
  } cmmp_vec_t;

endpackage

### hw/rtl/cmmp_front.sv
// Front end: complex multiply, product sums and CORDIC pre-rotation.
`timescale 1ns / 1ps
module cmmp_front #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic signed [OPERAND_WIDTH-1:0]   a_re,
  input  logic signed [OPERAND_WIDTH-1:0]   a_im,
  input  logic signed [OPERAND_WIDTH-1:0]   b_re,
  input  logic signed [OPERAND_WIDTH-1:0]   b_im,
  output logic                              out_valid,
  output logic signed [2*OPERAND_WIDTH:0]   out_prod_re,
  output logic signed [2*OPERAND_WIDTH:0]   out_prod_im,
  output cmmp_pkg::cmmp_vec_t               out_vec
);
  import cmmp_pkg::*;

  localparam int MW   = 2 * OPERAND_WIDTH;
  localparam int PW   = MW + 1;
  localparam int FRAC = 60 - MW;

  logic                 v1;
  logic                 v2;
  logic signed [MW-1:0] m_rr;
  logic signed [MW-1:0] m_ii;
  logic signed [MW-1:0] m_ri;
  logic signed [MW-1:0] m_ir;
  logic signed [PW-1:0] p_re;
  logic signed [PW-1:0] p_im;
  logic signed [XY_WIDTH-1:0] xs;
  logic signed [XY_WIDTH-1:0] ys;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= accept;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    m_rr <= a_re * b_re;
    m_ii <= a_im * b_im;
    m_ri <= a_re * b_im;
    m_ir <= a_im * b_re;
  end

  always_ff @(posedge clk) begin
    p_re <= {m_rr[MW-1], m_rr} - {m_ii[MW-1], m_ii};
    p_im <= {m_ri[MW-1], m_ri} + {m_ir[MW-1], m_ir};
  end

  assign xs = XY_WIDTH'(p_re) <<< FRAC;
  assign ys = XY_WIDTH'(p_im) <<< FRAC;

  always_ff @(posedge clk) begin
    out_prod_re  <= p_re;
    out_prod_im  <= p_im;
    out_vec.zero <= (p_re == '0) && (p_im == '0);
    if (p_re[PW-1]) begin
      out_vec.x <= -xs;
      out_vec.y <= -ys;
      out_vec.z <= p_im[PW-1] ? -PI_Q30 : PI_Q30;
    end else begin
      out_vec.x <= xs;
      out_vec.y <= ys;
      out_vec.z <= '0;
    end
  end

endmodule

### hw/rtl/cmmp_cordic_cell.sv
// One CORDIC vectoring cell with a fixed shift, registered toward the next cell.
`timescale 1ns / 1ps
module cmmp_cordic_cell #(
  parameter int PROD_WIDTH = 33,
  parameter int STEP       = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [PROD_WIDTH-1:0]  in_prod_re,
  input  logic signed [PROD_WIDTH-1:0]  in_prod_im,
  input  cmmp_pkg::cmmp_vec_t           in_vec,
  output logic                          out_valid,
  output logic signed [PROD_WIDTH-1:0]  out_prod_re,
  output logic signed [PROD_WIDTH-1:0]  out_prod_im,
  output cmmp_pkg::cmmp_vec_t           out_vec
);
  import cmmp_pkg::*;

  localparam logic signed [Z_WIDTH-1:0] ANGLE = $signed({3'b000, ATAN_Q30[STEP]});

  logic signed [XY_WIDTH-1:0] dx;
  logic signed [XY_WIDTH-1:0] dy;
  cmmp_vec_t                  vec_next;

  assign dx = in_vec.y >>> STEP;
  assign dy = in_vec.x >>> STEP;

  always_comb begin
    vec_next.zero = in_vec.zero;
    if (!in_vec.y[XY_WIDTH-1]) begin
      vec_next.x = in_vec.x + dx;
      vec_next.y = in_vec.y - dy;
      vec_next.z = in_vec.z + ANGLE;
    end else begin
      vec_next.x = in_vec.x - dx;
      vec_next.y = in_vec.y + dy;
      vec_next.z = in_vec.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_prod_re <= in_prod_re;
    out_prod_im <= in_prod_im;
    out_vec     <= vec_next;
  end

endmodule

### hw/rtl/cmmp_back.sv
// Back end: gain correction, magnitude rounding and phase rounding with clamp.
`timescale 1ns / 1ps
module cmmp_back #(
  parameter int OPERAND_WIDTH = 16,
  parameter int STEPS         = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic signed [2*OPERAND_WIDTH:0]        in_prod_re,
  input  logic signed [2*OPERAND_WIDTH:0]        in_prod_im,
  input  cmmp_pkg::cmmp_vec_t                    in_vec,
  output logic                                   done,
  output logic signed [2*OPERAND_WIDTH:0]        product_re,
  output logic signed [2*OPERAND_WIDTH:0]        product_im,
  output logic [cmmp_pkg::MAG_WIDTH-1:0]         magnitude,
  output logic signed [cmmp_pkg::PHASE_WIDTH-1:0] phase_angle
);
  import cmmp_pkg::*;

  localparam int PW   = 2 * OPERAND_WIDTH + 1;
  localparam int FRAC = 60 - 2 * OPERAND_WIDTH;
  localparam int S    = 2 * STEPS;
  localparam logic [63:0] GAIN_ADD =
    (S < 40) ? ((GAIN_TAIL + (64'd1 << (S - 1))) >> S) : 64'd0;
  localparam logic [GAIN_WIDTH-1:0] GAIN = GAIN_LIMIT + GAIN_ADD[GAIN_WIDTH-1:0];
  localparam int PR_WIDTH = Z_WIDTH - 17;
  localparam logic signed [PR_WIDTH-1:0] PH_MAX = PR_WIDTH'(PHASE_LIMIT);
  localparam logic signed [PR_WIDTH-1:0] PH_MIN = -PR_WIDTH'(PHASE_LIMIT);
  localparam logic [63:0] HALF = 64'd1 << (FRAC - 1);

  logic                        v1;
  logic                        v2;
  logic                        z1;
  logic                        z2;
  logic signed [PW-1:0]        re1;
  logic signed [PW-1:0]        im1;
  logic signed [PW-1:0]        re2;
  logic signed [PW-1:0]        im2;
  logic [63:0]                 hi_prod;
  logic [63:0]                 lo_prod;
  logic signed [Z_WIDTH-1:0]   z_round;
  logic signed [PR_WIDTH-1:0]  ph1;
  logic signed [PHASE_WIDTH-1:0] ph2;
  logic [63:0]                 r;
  logic [63:0]                 r_sum;
  logic [63:0]                 m_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      v2   <= v1;
      done <= v2;
    end
  end

  assign z_round = in_vec.z + (35'sd1 <<< 16);

  always_ff @(posedge clk) begin
    re1     <= in_prod_re;
    im1     <= in_prod_im;
    z1      <= in_vec.zero;
    hi_prod <= in_vec.x[63:32] * GAIN;
    lo_prod <= in_vec.x[31:0] * GAIN;
    ph1     <= z_round[Z_WIDTH-1:17];
  end

  always_ff @(posedge clk) begin
    re2 <= re1;
    im2 <= im1;
    z2  <= z1;
    r   <= hi_prod + {32'd0, lo_prod[63:32]};
    if (ph1 > PH_MAX) begin
      ph2 <= PH_MAX[PHASE_WIDTH-1:0];
    end else if (ph1 < PH_MIN) begin
      ph2 <= PH_MIN[PHASE_WIDTH-1:0];
    end else begin
      ph2 <= ph1[PHASE_WIDTH-1:0];
    end
  end

  assign r_sum  = r + HALF;
  assign m_full = r_sum >> FRAC;

  always_ff @(posedge clk) begin
    product_re <= re2;
    product_im <= im2;
    if (z2) begin
      magnitude   <= '0;
      phase_angle <= '0;
    end else begin
      magnitude   <= (|m_full[63:32]) ? '1 : m_full[31:0];
      phase_angle <= ph2;
    end
  end

endmodule

### hw/rtl/complex_multiply_magnitude_phase_core.sv
// Complex multiplier with CORDIC magnitude and phase, fully pipelined.
// A transaction starts when start is high and busy is low at a rising clock
// edge; busy is always low, so a new operand pair may be given every cycle.
// The operands a_re, a_im, b_re and b_im are sampled at that edge.
// Each result appears on product_re, product_im, magnitude and phase_angle
// for exactly one cycle, marked by done, and is taken at the edge ending it.
// The pipeline has three front stages for multiply, sum and pre-rotation,
// one cell per CORDIC iteration, and three back stages for gain multiply,
// sum and rounding.
// Throughput is one transaction per cycle, set by the row of CORDIC cells.
// The magnitude is the gain-corrected, rounded absolute value of the
// product; the phase is in radians, signed Q3.13, zero for a zero product.
// A synchronous reset clears every valid flag in the pipeline, so no result
// from before reset is ever reported; in-flight transactions are dropped.
// The receiver cannot stall, so results leave the pipeline unconditionally.
`timescale 1ns / 1ps
`include "complex_multiply_magnitude_phase_core_macros.svh"
module complex_multiply_magnitude_phase_core #(
  parameter int OPERAND_WIDTH = 16,
  parameter int CORDIC_STEPS  = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [OPERAND_WIDTH-1:0]        a_re,
  input  logic signed [OPERAND_WIDTH-1:0]        a_im,
  input  logic signed [OPERAND_WIDTH-1:0]        b_re,
  input  logic signed [OPERAND_WIDTH-1:0]        b_im,
  output logic                                   done,
  output logic signed [2*OPERAND_WIDTH:0]        product_re,
  output logic signed [2*OPERAND_WIDTH:0]        product_im,
  output logic [cmmp_pkg::MAG_WIDTH-1:0]         magnitude,
  output logic signed [cmmp_pkg::PHASE_WIDTH-1:0] phase_angle
);
  import cmmp_pkg::*;

  localparam int PW      = 2 * OPERAND_WIDTH + 1;
  localparam int LATENCY = CORDIC_STEPS + 6;

  logic                 accept;
  logic                 valid_chain [CORDIC_STEPS+1];
  logic signed [PW-1:0] re_chain    [CORDIC_STEPS+1];
  logic signed [PW-1:0] im_chain    [CORDIC_STEPS+1];
  cmmp_vec_t            vec_chain   [CORDIC_STEPS+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  cmmp_front #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .a_re        (a_re),
    .a_im        (a_im),
    .b_re        (b_re),
    .b_im        (b_im),
    .out_valid   (valid_chain[0]),
    .out_prod_re (re_chain[0]),
    .out_prod_im (im_chain[0]),
    .out_vec     (vec_chain[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    cmmp_cordic_cell #(
      .PROD_WIDTH(PW),
      .STEP      (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .in_valid    (valid_chain[i]),
      .in_prod_re  (re_chain[i]),
      .in_prod_im  (im_chain[i]),
      .in_vec      (vec_chain[i]),
      .out_valid   (valid_chain[i+1]),
      .out_prod_re (re_chain[i+1]),
      .out_prod_im (im_chain[i+1]),
      .out_vec     (vec_chain[i+1])
    );
  end

  cmmp_back #(
    .OPERAND_WIDTH(OPERAND_WIDTH),
    .STEPS        (CORDIC_STEPS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (valid_chain[CORDIC_STEPS]),
    .in_prod_re  (re_chain[CORDIC_STEPS]),
    .in_prod_im  (im_chain[CORDIC_STEPS]),
    .in_vec      (vec_chain[CORDIC_STEPS]),
    .done        (done),
    .product_re  (product_re),
    .product_im  (product_im),
    .magnitude   (magnitude),
    .phase_angle (phase_angle)
  );

  `CMMP_ASSERT_DLY(a_latency, accept, LATENCY, done, "Result did not follow a transaction.")
  `CMMP_ASSERT_IMP(a_zero_product, done && product_re == '0 && product_im == '0, magnitude == '0 && phase_angle == '0, "Zero product gave nonzero magnitude or phase.")
  `CMMP_ASSERT_IMP(a_nonzero_mag, done && (product_re != '0 || product_im != '0), magnitude != '0, "Nonzero product gave zero magnitude.")
  `CMMP_ASSERT_IMP(a_phase_range, done, $signed(phase_angle) <= PHASE_WIDTH'(PHASE_LIMIT) && $signed(phase_angle) >= -PHASE_WIDTH'(PHASE_LIMIT), "Phase out of range.")

endmodule

### test/complex_multiply_magnitude_phase_core_tb.sv
// Testbench for the complex multiply magnitude and phase core against a predictor.
`timescale 1ns / 1ps
module complex_multiply_magnitude_phase_core_tb;

  localparam int OW          = 16;
  localparam int STEPS       = 24;
  localparam int FRAC_BITS   = 60 - 2 * OW;
  localparam int PHASE_MAX   = 25736;
  localparam int LATENCY     = STEPS + 6;
  localparam int STALL_LIMIT = 1000;
  localparam longint PI_Q30  = 64'sd3373259426;
  localparam bit [63:0] GAIN_BASE = 64'h9B74EDA8;
  localparam bit [63:0] GAIN_TAIL = 64'd1738754331;
  localparam longint ATAN_STEP [0:31] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
    64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008,
    64'h00000004, 64'h00000002, 64'h00000001, 64'h00000000
  };

  typedef logic signed [OW-1:0] operand_t;

  typedef struct {
    logic signed [2*OW:0]                    re;
    logic signed [2*OW:0]                    im;
    logic [cmmp_pkg::MAG_WIDTH-1:0]          mag;
    logic signed [cmmp_pkg::PHASE_WIDTH-1:0] phase;
  } polar_product_t;

  class polar_product_tracker;
    polar_product_t awaited_products[$];
    int mismatches = 0;

    function automatic polar_product_t polar_product(operand_t ar, operand_t ai,
                                                     operand_t br, operand_t bi);
      polar_product_t p;
      longint pr, pim, x, y, z, dx, dy, ph;
      bit [63:0] ux, r, gain, mag;
      int s;
      pr  = longint'(ar) * longint'(br) - longint'(ai) * longint'(bi);
      pim = longint'(ar) * longint'(bi) + longint'(ai) * longint'(br);
      p.re = pr[2*OW:0];
      p.im = pim[2*OW:0];
      p.mag = '0;
      p.phase = '0;
      if (pr == 0 && pim == 0) begin
        return p;
      end
      x = pr * (longint'(1) << FRAC_BITS);
      y = pim * (longint'(1) << FRAC_BITS);
      z = 0;
      if (x < 0) begin
        z = (y >= 0) ? PI_Q30 : -PI_Q30;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_STEP[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_STEP[i];
        end
      end
      s = 2 * STEPS;
      gain = GAIN_BASE;
      if (s < 40) begin
        gain = gain + ((GAIN_TAIL + (64'd1 << (s - 1))) >> s);
      end
      ux = x;
      r = (ux >> 32) * gain + (((ux & 64'hFFFF_FFFF) * gain) >> 32);
      mag = (r + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (mag > 64'hFFFF_FFFF) begin
        mag = 64'hFFFF_FFFF;
      end
      ph = (z + (longint'(1) << 16)) >>> 17;
      if (ph > PHASE_MAX) begin
        ph = PHASE_MAX;
      end
      if (ph < -PHASE_MAX) begin
        ph = -PHASE_MAX;
      end
      p.mag = mag[31:0];
      p.phase = ph[15:0];
      return p;
    endfunction

    function void note_operands(operand_t ar, operand_t ai, operand_t br, operand_t bi);
      awaited_products.push_back(polar_product(ar, ai, br, bi));
    endfunction

    function void check_product(polar_product_t got);
      polar_product_t want;
      if (awaited_products.size() == 0) begin
        $error("result with no transaction outstanding: re %0d im %0d", got.re, got.im);
        mismatches++;
        return;
      end
      want = awaited_products.pop_front();
      if (got.re !== want.re) begin
        $error("product_re: expected %0d, got %0d", want.re, got.re);
        mismatches++;
      end
      if (got.im !== want.im) begin
        $error("product_im: expected %0d, got %0d", want.im, got.im);
        mismatches++;
      end
      if (got.mag !== want.mag) begin
        $error("magnitude: expected %0d, got %0d", want.mag, got.mag);
        mismatches++;
      end
      if (got.phase !== want.phase) begin
        $error("phase_angle: expected %0d, got %0d", want.phase, got.phase);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  operand_t a_re = '0;
  operand_t a_im = '0;
  operand_t b_re = '0;
  operand_t b_im = '0;
  logic busy;
  logic done;
  logic signed [2*OW:0] product_re;
  logic signed [2*OW:0] product_im;
  logic [cmmp_pkg::MAG_WIDTH-1:0] magnitude;
  logic signed [cmmp_pkg::PHASE_WIDTH-1:0] phase_angle;

  polar_product_tracker tracker = new();
  int stall_cycles = 0;

  complex_multiply_magnitude_phase_core #(
    .OPERAND_WIDTH(OW),
    .CORDIC_STEPS(STEPS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .a_re(a_re),
    .a_im(a_im),
    .b_re(b_re),
    .b_im(b_im),
    .done(done),
    .product_re(product_re),
    .product_im(product_im),
    .magnitude(magnitude),
    .phase_angle(phase_angle)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        tracker.note_operands(a_re, a_im, b_re, b_im);
      end
      if (done) begin
        tracker.check_product('{product_re, product_im, magnitude, phase_angle});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL complex_multiply_magnitude_phase_core");
      $finish;
    end
  end

  task automatic issue(input operand_t ar, input operand_t ai, input operand_t br,
                       input operand_t bi);
    start <= 1'b1;
    a_re <= ar;
    a_im <= ai;
    b_re <= br;
    b_im <= bi;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) begin
        a_re <= operand_t'($urandom);
        a_im <= operand_t'($urandom);
        b_re <= operand_t'($urandom);
        b_im <= operand_t'($urandom);
        @(posedge clk);
      end
    end
  endtask

  function automatic int gap_length(bit dense);
    int roll;
    roll = $urandom_range(0, 99);
    if (dense || roll < 55) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic operand_t random_operand();
    case ($urandom_range(0, 9))
      0: return operand_t'(-32768);
      1: return operand_t'(32767);
      2: return '0;
      3: return operand_t'(int'($urandom_range(0, 16)) - 8);
      default: return operand_t'($urandom);
    endcase
  endfunction

  task automatic issue_random(input bit dense);
    operand_t ar, ai, br, bi;
    ar = random_operand();
    ai = random_operand();
    br = random_operand();
    bi = random_operand();
    case ($urandom_range(0, 19))
      0: begin
        ar = '0;
        ai = '0;
      end
      1, 2: begin
        ai = '0;
        bi = '0;
      end
      3: begin
        br = ar;
        bi = -ai;
      end
      4: begin
        br = -ar;
        bi = ai;
      end
      default: ;
    endcase
    issue(ar, ai, br, bi);
    pause(gap_length(dense));
  endtask

  initial begin
    bit dense;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(0, 0, 0, 0);
    issue(1, 0, 0, 0);
    issue(0, 0, operand_t'(-32768), 32767);
    issue(1, 0, 1, 0);
    issue(operand_t'(-32768), 0, operand_t'(-32768), 0);
    issue(operand_t'(-32768), operand_t'(-32768), operand_t'(-32768), 32767);
    issue(operand_t'(-32768), 32767, 32767, operand_t'(-32768));
    issue(operand_t'(-5), 0, 3, 0);
    pause(2);
    issue(operand_t'(-32768), 0, 32767, 0);
    issue(0, 1, 1, 0);
    issue(0, operand_t'(-32768), 32767, 0);
    issue(operand_t'(-32768), operand_t'(-1), 32767, 0);
    issue(operand_t'(-32768), 1, 32767, 0);
    issue(operand_t'(-1), 0, 1, 0);
    pause(15);
    issue(32767, 32767, 32767, 32767);
    issue(operand_t'(-32768), operand_t'(-32768), operand_t'(-32768), operand_t'(-32768));
    issue(32767, operand_t'(-32768), operand_t'(-32768), 32767);
    issue(operand_t'(-1), operand_t'(-1), operand_t'(-1), operand_t'(-1));
    issue(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
    issue(1, 1, 1, operand_t'(-1));
    issue(3, operand_t'(-4), 3, 4);
    issue(operand_t'(-3), 4, 3, 4);
    pause(1);

    dense = 1'b0;
    for (int n = 0; n < 450; n++) begin
      if (n % 60 == 0) begin
        dense = ($urandom_range(0, 2) == 0);
      end
      issue_random(dense);
    end
    start <= 1'b0;

    while (tracker.awaited_products.size() > 0) begin
      @(posedge clk);
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("PASS complex_multiply_magnitude_phase_core");
    end else begin
      $display("FAIL complex_multiply_magnitude_phase_core");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/cmmp_pkg.sv
hw/rtl/cmmp_front.sv
hw/rtl/cmmp_cordic_cell.sv
hw/rtl/cmmp_back.sv
hw/rtl/complex_multiply_magnitude_phase_core.sv
test/complex_multiply_magnitude_phase_core_tb.sv
